### rtl/core/taf_pkg.sv
// Shared types, constants and helpers for the three-axis admittance filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package taf_pkg;

    localparam int unsigned DataW  = 32;
    localparam int unsigned TsW    = 17;
    localparam int unsigned ProdW  = 64;
    localparam int unsigned FlW    = ProdW - 16;
    localparam int unsigned AccW   = FlW + 1;
    localparam int unsigned WideW  = AccW + 2;
    localparam int unsigned NumAxes = 3;

    localparam logic [DataW-1:0] InvMassReset  = 32'd2184533;
    localparam logic [DataW-1:0] DampingReset  = 32'd6554;
    localparam logic [DataW-1:0] SpringReset   = 32'd0;
    localparam logic [TsW-1:0]   TimeStepReset = 17'd655;

    typedef enum logic [1:0] {
        REG_INV_MASS  = 2'd0,
        REG_DAMPING   = 2'd1,
        REG_SPRING    = 2'd2,
        REG_TIME_STEP = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DAMP,
        ST_SPR,
        ST_NUM,
        ST_AMUL,
        ST_ASAT,
        ST_VMUL,
        ST_VEL,
        ST_OMUL,
        ST_OFF,
        ST_TGT,
        ST_OUT
    } t_step;

    typedef struct packed {
        logic [DataW-1:0] inv_mass;
        logic [DataW-1:0] damping;
        logic [DataW-1:0] spring;
        logic [TsW-1:0]   time_step;
    } t_cfg;

    typedef struct packed {
        logic  load;
        t_step step;
    } t_lane_ctl;

    function automatic logic signed [DataW-1:0] f_sat32(input logic signed [WideW-1:0] x);
        logic signed [WideW-1:0] hi;
        logic signed [WideW-1:0] lo;
        hi = WideW'(signed'(33'sh0_7FFF_FFFF));
        lo = -hi - WideW'(1);
        if (x > hi) begin
            f_sat32 = {1'b0, {(DataW-1){1'b1}}};
        end else if (x < lo) begin
            f_sat32 = {1'b1, {(DataW-1){1'b0}}};
        end else begin
            f_sat32 = x[DataW-1:0];
        end
    endfunction

endpackage

`default_nettype wire

### rtl/core/taf_lane.sv
// One axis lane: multiply sequence for damping, spring, mass and integration.
// Uses taf_pkg; stepped by the top-level sequencer, one shared multiplier per lane.
`timescale 1ns / 1ps
`default_nettype none

module taf_lane
    import taf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_lane_ctl         i_ctl,
    input  wire t_cfg              i_cfg,
    input  wire logic [DataW-1:0]  i_force,
    input  wire logic [DataW-1:0]  i_pose,
    output logic [DataW-1:0]       o_target
);

    logic signed [DataW-1:0] r_force;
    logic signed [DataW-1:0] r_pose;
    logic signed [DataW-1:0] r_vel;
    logic signed [DataW-1:0] r_off;
    logic signed [DataW-1:0] r_n;
    logic signed [DataW-1:0] r_a;
    logic signed [DataW-1:0] r_target;
    logic signed [AccW-1:0]  r_acc;
    logic signed [ProdW-1:0] r_prod;

    logic signed [DataW:0]     w_ma;
    logic signed [DataW-1:0]   w_mb;
    logic signed [DataW*2:0]   w_mul;
    logic signed [FlW-1:0]     w_fl;

    always_comb begin
        case (i_ctl.step)
            ST_DAMP: begin
                w_ma = {1'b0, i_cfg.damping};
                w_mb = r_vel;
            end
            ST_SPR: begin
                w_ma = {1'b0, i_cfg.spring};
                w_mb = r_off;
            end
            ST_AMUL: begin
                w_ma = {1'b0, i_cfg.inv_mass};
                w_mb = r_n;
            end
            ST_VMUL: begin
                w_ma = {{(DataW+1-TsW){1'b0}}, i_cfg.time_step};
                w_mb = r_a;
            end
            ST_OMUL: begin
                w_ma = {{(DataW+1-TsW){1'b0}}, i_cfg.time_step};
                w_mb = r_vel;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_mul = w_ma * w_mb;
    // floor of product / 2^16
    assign w_fl  = r_prod[ProdW-1:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel <= '0;
            r_off <= '0;
        end else begin
            case (i_ctl.step)
                ST_VEL: r_vel <= f_sat32(WideW'(r_vel) + WideW'(w_fl));
                ST_OFF: r_off <= f_sat32(WideW'(r_off) + WideW'(w_fl));
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_force <= i_force;
            r_pose  <= i_pose;
        end
        case (i_ctl.step)
            ST_DAMP, ST_SPR, ST_AMUL, ST_VMUL, ST_OMUL: r_prod <= w_mul[ProdW-1:0];
            default: ;
        endcase
        case (i_ctl.step)
            ST_SPR:  r_acc    <= AccW'(r_force) - AccW'(w_fl);
            ST_NUM:  r_n      <= f_sat32(WideW'(r_acc) - WideW'(w_fl));
            ST_ASAT: r_a      <= f_sat32(WideW'(w_fl));
            ST_TGT:  r_target <= f_sat32(WideW'(r_pose) + WideW'(r_off));
            default: ;
        endcase
    end

    assign o_target = r_target;

endmodule

`default_nettype wire

### rtl/core/taf_merge.sv
// Merging output stage: registers the three lane targets as one result transfer.
// Uses taf_pkg; valid/stall handshake toward the consumer.
`timescale 1ns / 1ps
`default_nettype none

module taf_merge
    import taf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire logic [DataW-1:0]  i_target_x,
    input  wire logic [DataW-1:0]  i_target_y,
    input  wire logic [DataW-1:0]  i_target_z,
    input  wire logic              i_out_stall,
    output logic                   o_free,
    output logic                   o_out_valid,
    output logic [DataW-1:0]       o_target_x,
    output logic [DataW-1:0]       o_target_y,
    output logic [DataW-1:0]       o_target_z
);

    logic             r_valid;
    logic [DataW-1:0] r_tx;
    logic [DataW-1:0] r_ty;
    logic [DataW-1:0] r_tz;

    assign o_free = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_tx <= i_target_x;
            r_ty <= i_target_y;
            r_tz <= i_target_z;
        end
    end

    assign o_out_valid = r_valid;
    assign o_target_x  = r_tx;
    assign o_target_y  = r_ty;
    assign o_target_z  = r_tz;

endmodule

`default_nettype wire

### rtl/core/three_axis_admittance_filter.sv
// Three-axis admittance filter, top level: sequencer, config registers, three lanes.
// Each item passes through the five-multiply sequence of each lane before its result is
// registered; a new item is taken only after the previous one has left the sequence.
// Input stalls while an item is in flight or its result cannot enter the output register.
// Synchronous active-low reset: gains to defaults, velocity and offset to zero.
// Depends on taf_pkg, taf_lane, taf_merge.
`timescale 1ns / 1ps
`default_nettype none

module three_axis_admittance_filter
    import taf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [DataW-1:0]  i_force_x,
    input  wire logic [DataW-1:0]  i_force_y,
    input  wire logic [DataW-1:0]  i_force_z,
    input  wire logic [DataW-1:0]  i_pose_x,
    input  wire logic [DataW-1:0]  i_pose_y,
    input  wire logic [DataW-1:0]  i_pose_z,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [DataW-1:0]       o_target_x,
    output logic [DataW-1:0]       o_target_y,
    output logic [DataW-1:0]       o_target_z,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [DataW-1:0]  i_cfg_data
);

    t_step      r_state;
    t_step      n_state;
    t_cfg       r_cfg;
    t_lane_ctl  w_ctl;
    logic       w_accept;
    logic       w_merge_load;
    logic       w_merge_free;
    logic [DataW-1:0] w_nfz;
    logic [DataW-1:0] w_target [NumAxes];

    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inv_mass  <= InvMassReset;
            r_cfg.damping   <= DampingReset;
            r_cfg.spring    <= SpringReset;
            r_cfg.time_step <= TimeStepReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg_idx'(i_cfg_index))
                REG_INV_MASS:  r_cfg.inv_mass  <= i_cfg_data;
                REG_DAMPING:   r_cfg.damping   <= i_cfg_data;
                REG_SPRING:    r_cfg.spring    <= i_cfg_data;
                REG_TIME_STEP: r_cfg.time_step <= i_cfg_data[TsW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        case (r_state)
            ST_IDLE: n_state = i_in_valid ? ST_DAMP : ST_IDLE;
            ST_DAMP: n_state = ST_SPR;
            ST_SPR:  n_state = ST_NUM;
            ST_NUM:  n_state = ST_AMUL;
            ST_AMUL: n_state = ST_ASAT;
            ST_ASAT: n_state = ST_VMUL;
            ST_VMUL: n_state = ST_VEL;
            ST_VEL:  n_state = ST_OMUL;
            ST_OMUL: n_state = ST_OFF;
            ST_OFF:  n_state = ST_TGT;
            ST_TGT:  n_state = ST_OUT;
            ST_OUT:  n_state = w_merge_free ? ST_IDLE : ST_OUT;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall   = (r_state != ST_IDLE);
        w_ctl.load   = w_accept;
        w_ctl.step   = r_state;
        w_merge_load = (r_state == ST_OUT) && w_merge_free;
    end

    // negated z force, saturating the most negative value
    assign w_nfz = (i_force_z == {1'b1, {(DataW-1){1'b0}}}) ?
                   {1'b0, {(DataW-1){1'b1}}} : (~i_force_z + DataW'(1));

    taf_lane u_lane_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_cfg    (r_cfg),
        .i_force  (i_force_y),
        .i_pose   (i_pose_x),
        .o_target (w_target[0])
    );

    taf_lane u_lane_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_cfg    (r_cfg),
        .i_force  (i_force_x),
        .i_pose   (i_pose_y),
        .o_target (w_target[1])
    );

    taf_lane u_lane_z (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_cfg    (r_cfg),
        .i_force  (w_nfz),
        .i_pose   (i_pose_z),
        .o_target (w_target[2])
    );

    taf_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_merge_load),
        .i_target_x  (w_target[0]),
        .i_target_y  (w_target[1]),
        .i_target_z  (w_target[2]),
        .i_out_stall (i_out_stall),
        .o_free      (w_merge_free),
        .o_out_valid (o_out_valid),
        .o_target_x  (o_target_x),
        .o_target_y  (o_target_y),
        .o_target_z  (o_target_z)
    );

`ifndef ASSERT_OFF
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_DAMP))
        else $error("accepted transfer did not start the sequence");

    a_tgt_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TGT) |=> (r_state == ST_OUT) && !o_in_stall == 1'b0)
        else $error("target step not followed by output step");

    a_out_blocked_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_OUT) && o_out_valid && i_out_stall) |=> (r_state == ST_OUT))
        else $error("result dropped while output register was stalled");
`endif

endmodule

`default_nettype wire

### sim/three_axis_admittance_filter_test.sv
// Self-checking testbench for three_axis_admittance_filter: drives control ticks and register
// writes, predicts each target triple from its own Q16.16 filter model and checks it in order.
// Depends on taf_pkg and the block's RTL only.
`timescale 1ns / 1ps

module three_axis_admittance_filter_test;
    import taf_pkg::*;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [31:0] pose_z;
    } t_tick;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_target;

    localparam longint QMax = 64'sd2147483647;
    localparam longint QMin = -QMax - 1;
    localparam logic signed [31:0] PosFull = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] NegFull = 32'sh8000_0000;
    localparam logic signed [31:0] OneQ = 32'sh0001_0000;
    localparam int SettleCycles = 16;
    localparam int DrainGuard = 5000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [DataW-1:0] force_x = '0;
    logic [DataW-1:0] force_y = '0;
    logic [DataW-1:0] force_z = '0;
    logic [DataW-1:0] pose_x = '0;
    logic [DataW-1:0] pose_y = '0;
    logic [DataW-1:0] pose_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [DataW-1:0] target_x;
    logic [DataW-1:0] target_y;
    logic [DataW-1:0] target_z;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [DataW-1:0] cfg_data = '0;

    // filter model state
    logic [31:0] cur_inv_mass;
    logic [31:0] cur_damping;
    logic [31:0] cur_spring;
    logic [16:0] cur_time_step;
    logic signed [31:0] axis_vel [3];
    logic signed [31:0] axis_off [3];

    t_target pending_targets [$];
    bit idle_on = 1'b1;
    int rx_hold_request = 0;
    int fail_count = 0;
    int ticks_sent = 0;
    int results_seen = 0;
    int cfg_writes = 0;
    int settings_used = 0;

    three_axis_admittance_filter dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_force_x   (force_x),
        .i_force_y   (force_y),
        .i_force_z   (force_z),
        .i_pose_x    (pose_x),
        .i_pose_y    (pose_y),
        .i_pose_z    (pose_z),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_target_x  (target_x),
        .o_target_y  (target_y),
        .o_target_z  (target_z),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic signed [31:0] clamp32(input longint x);
        if (x > QMax) begin
            return PosFull;
        end
        if (x < QMin) begin
            return NegFull;
        end
        return x[31:0];
    endfunction

    // unsigned Q16.16 gain times signed Q16.16 value, floored
    function automatic longint scale_q16(input logic [31:0] gain, input logic signed [31:0] value);
        longint g;
        longint v;
        g = longint'({32'd0, gain});
        v = value;
        return (g * v) >>> 16;
    endfunction

    function automatic logic signed [31:0] step_axis(input int k, input logic signed [31:0] f,
                                                     input logic signed [31:0] p);
        longint num;
        logic signed [31:0] n;
        logic signed [31:0] a;
        num = longint'(f) - scale_q16(cur_damping, axis_vel[k])
              - scale_q16(cur_spring, axis_off[k]);
        n = clamp32(num);
        a = clamp32(scale_q16(cur_inv_mass, n));
        axis_vel[k] = clamp32(longint'(axis_vel[k]) + scale_q16({15'd0, cur_time_step}, a));
        axis_off[k] = clamp32(longint'(axis_off[k])
                              + scale_q16({15'd0, cur_time_step}, axis_vel[k]));
        return clamp32(longint'(p) + longint'(axis_off[k]));
    endfunction

    // axis x follows force y, axis y follows force x, axis z the negated force z
    function automatic t_target filter_tick(input t_tick t);
        t_target r;
        logic signed [31:0] neg_fz;
        neg_fz = clamp32(-longint'($signed(t.force_z)));
        r.x = step_axis(0, $signed(t.force_y), $signed(t.pose_x));
        r.y = step_axis(1, $signed(t.force_x), $signed(t.pose_y));
        r.z = step_axis(2, neg_fz, $signed(t.pose_z));
        return r;
    endfunction

    function automatic t_tick make_tick(input logic signed [31:0] fx, fy, fz, px, py, pz);
        t_tick t;
        t.force_x = fx;
        t.force_y = fy;
        t.force_z = fz;
        t.pose_x = px;
        t.pose_y = py;
        t.pose_z = pz;
        return t;
    endfunction

    function automatic logic signed [31:0] rand_force();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return $signed($urandom);
        end
        if (r < 3) begin
            return $signed($urandom) >>> 8;
        end
        return $signed($urandom) >>> 14;
    endfunction

    function automatic logic signed [31:0] rand_pose();
        if ($urandom_range(0, 4) == 0) begin
            return $signed($urandom);
        end
        return $signed($urandom) >>> 10;
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 5))
            0: begin
                return 32'd0;
            end
            1: begin
                return 32'hFFFF_FFFF;
            end
            2: begin
                return $urandom_range(0, 32'h0004_0000);
            end
            3: begin
                return $urandom;
            end
            default: begin
                return $urandom_range(32'h100, 32'h0100_0000);
            end
        endcase
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 5))
            0: begin
                return 32'd0;
            end
            1: begin
                return 32'd65536;
            end
            2: begin
                return $urandom;
            end
            default: begin
                return $urandom_range(1, 4000);
            end
        endcase
    endfunction

    task automatic write_register(input t_reg_idx idx, input logic [31:0] value);
        bit took;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do begin
            @(negedge clk);
            took = cfg_ready;
            @(posedge clk);
        end while (!took);
        cfg_valid <= 1'b0;
        case (idx)
            REG_INV_MASS: begin
                cur_inv_mass = value;
            end
            REG_DAMPING: begin
                cur_damping = value;
            end
            REG_SPRING: begin
                cur_spring = value;
            end
            REG_TIME_STEP: begin
                cur_time_step = value[16:0];
            end
            default: ;
        endcase
        cfg_writes++;
        @(posedge clk);
    endtask

    task automatic write_all(input logic [31:0] inv_mass, damping, spring, time_step);
        write_register(REG_INV_MASS, inv_mass);
        write_register(REG_DAMPING, damping);
        write_register(REG_SPRING, spring);
        write_register(REG_TIME_STEP, time_step);
        settings_used++;
    endtask

    task automatic send_tick(input t_tick t);
        int gap;
        bit took;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        force_x <= t.force_x;
        force_y <= t.force_y;
        force_z <= t.force_z;
        pose_x <= t.pose_x;
        pose_y <= t.pose_y;
        pose_z <= t.pose_z;
        do begin
            @(negedge clk);
            took = !in_stall;
            @(posedge clk);
        end while (!took);
        pending_targets = {pending_targets, filter_tick(t)};
        ticks_sent++;
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (pending_targets.size() != 0 && guard < DrainGuard) begin
            @(posedge clk);
            guard++;
        end
        if (pending_targets.size() != 0) begin
            $error("%0d results never arrived", pending_targets.size());
            fail_count++;
            pending_targets.delete();
        end
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        send_tick(make_tick(0, 0, 0, 0, 0, 0));
        send_tick(make_tick(-OneQ, OneQ, 2 * OneQ, OneQ, -OneQ, 3 * OneQ));
        send_tick(make_tick(OneQ, -OneQ, -OneQ, 0, 0, 0));
    endtask

    task automatic test_every_register();
        wait_drained();
        write_all(32'd65536, 32'd0, 32'd65536, 32'd65536);
        send_tick(make_tick(OneQ, OneQ, OneQ, 0, 0, 0));
        send_tick(make_tick(0, 0, 0, OneQ, OneQ, OneQ));
    endtask

    task automatic test_saturation_extremes();
        wait_drained();
        // upper time-step bits are dropped, leaving a step above one second
        write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_tick(make_tick(PosFull, PosFull, PosFull, PosFull, PosFull, PosFull));
        send_tick(make_tick(NegFull, NegFull, NegFull, NegFull, NegFull, NegFull));
        send_tick(make_tick(0, 0, NegFull, 0, 0, 0));
        send_tick(make_tick(NegFull, NegFull, PosFull, PosFull, PosFull, NegFull));
        wait_drained();
        write_register(REG_TIME_STEP, 32'd0);
        settings_used++;
        send_tick(make_tick(PosFull, NegFull, PosFull, 0, 0, 0));
        send_tick(make_tick(OneQ, OneQ, OneQ, NegFull, PosFull, 0));
        wait_drained();
        write_all(32'd0, 32'd0, 32'd0, 32'd65536);
        send_tick(make_tick(PosFull, PosFull, NegFull, OneQ, OneQ, OneQ));
        send_tick(make_tick(0, 0, 0, PosFull, NegFull, PosFull));
        wait_drained();
        write_all(InvMassReset, DampingReset, 32'd20000, TimeStepReset);
    endtask

    task automatic test_long_output_hold();
        int k;
        t_tick t;
        wait_drained();
        idle_on = 1'b0;
        rx_hold_request = 400;
        for (k = 0; k < 40; k++) begin
            t = make_tick(rand_force(), rand_force(), rand_force(),
                          rand_pose(), rand_pose(), rand_pose());
            send_tick(t);
        end
        wait_drained();
        idle_on = 1'b1;
    endtask

    task automatic test_random_phase(input int n_ticks, input bit idling);
        int k;
        t_tick t;
        t_tick fresh;
        wait_drained();
        write_all(pick_gain(), pick_gain(), pick_gain(), pick_step());
        idle_on = idling;
        t = make_tick(rand_force(), rand_force(), rand_force(), 0, 0, 0);
        for (k = 0; k < n_ticks; k++) begin
            fresh = make_tick(rand_force(), rand_force(), rand_force(),
                              rand_pose(), rand_pose(), rand_pose());
            // forces mostly hold for a few ticks to give step responses
            if ($urandom_range(0, 3) == 0) begin
                t = fresh;
            end else begin
                t.pose_x = fresh.pose_x;
                t.pose_y = fresh.pose_y;
                t.pose_z = fresh.pose_z;
            end
            send_tick(t);
        end
    endtask

    initial begin : result_sink
        int wait_cycles;
        bit took;
        @(posedge clk);
        forever begin
            if (rx_hold_request > 0) begin
                wait_cycles = rx_hold_request;
                rx_hold_request = 0;
            end else begin
                wait_cycles = idle_on ? $urandom_range(0, 4) : 0;
            end
            if (wait_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do begin
                @(negedge clk);
                took = out_valid && rst_n;
                @(posedge clk);
            end while (!took);
        end
    end

    // outputs are settled at the falling edge; a transfer there completes at the next rising edge
    always @(negedge clk) begin : result_check
        t_target want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_targets.size() == 0) begin
                $error("result transfer with nothing expected");
                fail_count++;
            end else begin
                want = pending_targets.pop_front();
                results_seen++;
                if (target_x !== want.x) begin
                    $error("target_x: expected %0d, actual %0d", want.x, $signed(target_x));
                    fail_count++;
                end
                if (target_y !== want.y) begin
                    $error("target_y: expected %0d, actual %0d", want.y, $signed(target_y));
                    fail_count++;
                end
                if (target_z !== want.z) begin
                    $error("target_z: expected %0d, actual %0d", want.z, $signed(target_z));
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int p;
        cur_inv_mass = InvMassReset;
        cur_damping = DampingReset;
        cur_spring = SpringReset;
        cur_time_step = TimeStepReset;
        for (p = 0; p < 3; p++) begin
            axis_vel[p] = '0;
            axis_off[p] = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_every_register();
        test_saturation_extremes();
        test_long_output_hold();
        for (p = 0; p < 9; p++) begin
            test_random_phase(150, p % 3 != 1);
        end
        wait_drained();

        $display("Covered %0d control ticks, %0d checked results, %0d register writes",
                 ticks_sent, results_seen, cfg_writes);
        $display("over %0d gain settings, with saturation cases and a long output hold-off",
                 settings_used);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
rtl/core/taf_pkg.sv
rtl/core/taf_lane.sv
rtl/core/taf_merge.sv
rtl/core/three_axis_admittance_filter.sv
sim/three_axis_admittance_filter_test.sv
